FILE: hw/rtl/srb_pkg.sv
// Package for the stream byte reassembler.
// Holds window sizing, field widths, result kinds and the control state type.
// No dependencies.
package srb_pkg;

   localparam int WINDOW_BYTES = 64;
   localparam int RESULT_LIMIT = 64;

   localparam int SLOT_W  = $clog2(WINDOW_BYTES);
   localparam int COUNT_W = $clog2(WINDOW_BYTES + 1);
   localparam int RUN_W   = $clog2(RESULT_LIMIT + 1);
   localparam int INDEX_W = 32;
   localparam int BYTE_W  = 8;
   localparam int SPACE_W = 7;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DRAIN = 3'b010,
      ST_OUT   = 3'b100
   } state_type;

endpackage

FILE: hw/rtl/stream_byte_reassembler_unit.sv
// Top level of the stream byte reassembler: window control, valid bits and result stage.
// Depends on srb_pkg and srb_ram (byte ring storage).
//
// Bytes arrive one per transfer with their absolute 32-bit stream index and are kept
// in a ring of srb_pkg::WINDOW_BYTES entries when they fall inside the window
// [next expected, next expected + available_space); all other bytes are dropped.
// After each input transfer the block delivers every contiguous stored byte from the
// next expected index, in order, then a close result once the known end is reached;
// after the close all input is taken and ignored. rsp_tlast marks the final result
// caused by one input. Timing: an input is taken and stored in ST_IDLE, then each result
// takes a ring read (ST_DRAIN), then the output transfer (ST_OUT, held by back-pressure);
// an input with no result passes through ST_DRAIN only. Results are serialised by the
// single result register: the next ring read waits for the current transfer.
// No input is taken while results of the previous one remain.
module stream_byte_reassembler_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // stream_index[31:0], byte_value[39:32], available_space[46:40], zero fill
   input  logic [srb_pkg::REQ_DATA_W-1:0] req_tdata,
   // byte_present
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_byte[7:0], out_index[39:8], pending_count[46:40], zero fill
   output logic [srb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_kind
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);

   srb_pkg::state_type state_ff, state_in;

   logic [srb_pkg::WINDOW_BYTES-1:0] valid_ff, valid_in;
   logic [srb_pkg::INDEX_W-1:0]      next_ff, next_in;
   logic [srb_pkg::SLOT_W-1:0]       head_ff, head_in;
   logic                             end_known_ff, end_known_in;
   logic [srb_pkg::INDEX_W-1:0]      end_pos_ff, end_pos_in;
   logic [srb_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             closed_ff, closed_in;
   logic [srb_pkg::RUN_W-1:0]        run_ff, run_in;

   logic                             out_kind_ff, out_kind_in;
   logic [srb_pkg::INDEX_W-1:0]      out_index_ff, out_index_in;
   logic [srb_pkg::COUNT_W-1:0]      out_pend_ff, out_pend_in;
   logic                             out_last_ff, out_last_in;

   logic [srb_pkg::INDEX_W-1:0]      in_index;
   logic [srb_pkg::BYTE_W-1:0]       in_byte;
   logic [srb_pkg::SPACE_W-1:0]      in_space;
   logic [srb_pkg::SPACE_W-1:0]      space;
   logic [srb_pkg::INDEX_W-1:0]      offset;
   logic [srb_pkg::INDEX_W-1:0]      end_value;
   logic [srb_pkg::INDEX_W-1:0]      end_dist;
   logic [srb_pkg::SLOT_W:0]         slot_sum;
   logic [srb_pkg::SLOT_W-1:0]       slot;
   logic [srb_pkg::SLOT_W-1:0]       head_nx;
   logic [srb_pkg::INDEX_W-1:0]      next_plus;
   logic [srb_pkg::COUNT_W-1:0]      count_dec;
   logic                             run_room;
   logic                             run_room_nx;
   logic                             accept;

   logic                             ram_wr_en;
   logic                             ram_rd_en;
   logic [srb_pkg::BYTE_W-1:0]       ram_rd_data;

   assign in_index = req_tdata[31:0];
   assign in_byte  = req_tdata[39:32];
   assign in_space = req_tdata[46:40];

   assign req_tready = (state_ff == srb_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign space = (in_space > srb_pkg::SPACE_W'(srb_pkg::WINDOW_BYTES))
                ? srb_pkg::SPACE_W'(srb_pkg::WINDOW_BYTES) : in_space;
   assign offset    = in_index - next_ff;
   assign end_value = req_tuser ? (in_index + 32'd1) : in_index;
   assign end_dist  = end_value - next_ff;

   assign slot_sum = {1'b0, head_ff} + {1'b0, offset[srb_pkg::SLOT_W-1:0]};
   assign slot = (slot_sum >= (srb_pkg::SLOT_W + 1)'(srb_pkg::WINDOW_BYTES))
               ? srb_pkg::SLOT_W'(slot_sum - (srb_pkg::SLOT_W + 1)'(srb_pkg::WINDOW_BYTES))
               : slot_sum[srb_pkg::SLOT_W-1:0];

   assign head_nx = (head_ff == srb_pkg::SLOT_W'(srb_pkg::WINDOW_BYTES - 1))
                  ? '0 : head_ff + srb_pkg::SLOT_W'(1);
   assign next_plus   = next_ff + 32'd1;
   assign count_dec   = (count_ff != '0) ? count_ff - srb_pkg::COUNT_W'(1) : count_ff;
   assign run_room    = run_ff < srb_pkg::RUN_W'(srb_pkg::RESULT_LIMIT);
   assign run_room_nx = (run_ff + srb_pkg::RUN_W'(1)) < srb_pkg::RUN_W'(srb_pkg::RESULT_LIMIT);

   assign ram_wr_en = accept && !closed_ff && req_tuser
                   && (offset < {{(srb_pkg::INDEX_W - srb_pkg::SPACE_W){1'b0}}, space})
                   && !valid_ff[slot];

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      next_in      = next_ff;
      head_in      = head_ff;
      end_known_in = end_known_ff;
      end_pos_in   = end_pos_ff;
      count_in     = count_ff;
      closed_in    = closed_ff;
      run_in       = run_ff;
      out_kind_in  = out_kind_ff;
      out_index_in = out_index_ff;
      out_pend_in  = out_pend_ff;
      out_last_in  = out_last_ff;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         srb_pkg::ST_IDLE: begin
            if (accept && !closed_ff) begin
               if (ram_wr_en) begin
                  valid_in[slot] = 1'b1;
                  count_in       = count_ff + srb_pkg::COUNT_W'(1);
               end
               if (req_tlast
                   && (end_dist <= {{(srb_pkg::INDEX_W - srb_pkg::SPACE_W){1'b0}}, space})) begin
                  end_known_in = 1'b1;
                  end_pos_in   = end_value;
               end
               run_in   = '0;
               state_in = srb_pkg::ST_DRAIN;
            end
         end
         srb_pkg::ST_DRAIN: begin
            priority if (run_room && valid_ff[head_ff]) begin
               ram_rd_en         = 1'b1;
               valid_in[head_ff] = 1'b0;
               count_in          = count_dec;
               out_kind_in       = srb_pkg::KIND_DATA;
               out_index_in      = next_ff;
               out_pend_in       = count_dec;
               out_last_in       = !(run_room_nx
                                   && (valid_ff[head_nx]
                                       || (end_known_ff && (next_plus == end_pos_ff))));
               next_in           = next_plus;
               head_in           = head_nx;
               run_in            = run_ff + srb_pkg::RUN_W'(1);
               state_in          = srb_pkg::ST_OUT;
            end else if (run_room && end_known_ff && (next_ff == end_pos_ff)) begin
               valid_in     = '0;
               count_in     = '0;
               closed_in    = 1'b1;
               out_kind_in  = srb_pkg::KIND_CLOSE;
               out_index_in = end_pos_ff;
               out_pend_in  = '0;
               out_last_in  = 1'b1;
               state_in     = srb_pkg::ST_OUT;
            end else begin
               state_in = srb_pkg::ST_IDLE;
            end
         end
         srb_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = out_last_ff ? srb_pkg::ST_IDLE : srb_pkg::ST_DRAIN;
            end
         end
         default: begin
            state_in = srb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srb_pkg::ST_IDLE;
         valid_ff     <= '0;
         next_ff      <= '0;
         head_ff      <= '0;
         end_known_ff <= 1'b0;
         end_pos_ff   <= '0;
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         run_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         next_ff      <= next_in;
         head_ff      <= head_in;
         end_known_ff <= end_known_in;
         end_pos_ff   <= end_pos_in;
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         run_ff       <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_index_ff <= out_index_in;
      out_pend_ff  <= out_pend_in;
      out_last_ff  <= out_last_in;
   end

   srb_ram #(
      .WIDTH (srb_pkg::BYTE_W),
      .DEPTH (srb_pkg::WINDOW_BYTES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot),
      .wr_data (in_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = (state_ff == srb_pkg::ST_OUT);
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_pend_ff, out_index_ff,
                        (out_kind_ff == srb_pkg::KIND_CLOSE) ? {srb_pkg::BYTE_W{1'b0}}
                                                             : ram_rd_data};

endmodule

FILE: hw/rtl/srb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds while rd_en is low. No dependencies.
module srb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/reassembly_checker.sv
// Delivery checker for the stream byte reassembler: follows both channels, predicts
// every in-order byte and the close from the input transfers, and compares them in order.
// Depends on srb_pkg for window sizing and field widths.
`timescale 1ns / 100ps

module reassembly_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // stream_index[31:0], byte_value[39:32], available_space[46:40], zero fill
   input  logic [srb_pkg::REQ_DATA_W-1:0] req_tdata,
   // byte_present
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_byte[7:0], out_index[39:8], pending_count[46:40], zero fill
   input  logic [srb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_kind
   input  logic                           rsp_tuser,
   input  logic                           rsp_tlast,
   output int                             mismatch_count,
   output int                             outstanding_results,
   output logic [srb_pkg::INDEX_W-1:0]    predicted_next
);

   typedef struct packed {
      logic                        kind;
      logic [srb_pkg::BYTE_W-1:0]  data;
      logic [srb_pkg::INDEX_W-1:0] index;
      logic [srb_pkg::COUNT_W-1:0] held;
      logic                        run_end;
   } delivery_type;

   logic [srb_pkg::BYTE_W-1:0]  ring_bytes [srb_pkg::WINDOW_BYTES];
   bit                          ring_valid [srb_pkg::WINDOW_BYTES];
   logic [srb_pkg::INDEX_W-1:0] next_index;
   logic [srb_pkg::INDEX_W-1:0] end_mark;
   bit                          end_known;
   bit                          stream_closed;
   int                          held_bytes;
   int                          head_slot;
   int                          error_total = 0;
   delivery_type                expected_deliveries[$];

   task automatic absorb_transfer(input logic [srb_pkg::INDEX_W-1:0] index,
                                  input logic [srb_pkg::BYTE_W-1:0] value,
                                  input logic present,
                                  input logic final_mark,
                                  input logic [srb_pkg::SPACE_W-1:0] space_field);
      int unsigned                 space;
      int                          slot;
      logic [srb_pkg::INDEX_W-1:0] offset;
      logic [srb_pkg::INDEX_W-1:0] end_gap;
      delivery_type                batch[$];
      delivery_type                item;
      if (stream_closed) return;
      space = (space_field > srb_pkg::WINDOW_BYTES) ? srb_pkg::WINDOW_BYTES : space_field;
      if (present) begin
         offset = index - next_index;
         if (offset < space) begin
            slot = int'((head_slot + offset) % srb_pkg::WINDOW_BYTES);
            if (!ring_valid[slot]) begin
               ring_bytes[slot] = value;
               ring_valid[slot] = 1'b1;
               held_bytes++;
            end
         end
         if (final_mark) begin
            end_gap = index + 32'd1 - next_index;
            if (end_gap <= space) begin
               end_known = 1'b1;
               end_mark  = index + 32'd1;
            end
         end
      end else if (final_mark) begin
         end_gap = index - next_index;
         if (end_gap <= space) begin
            end_known = 1'b1;
            end_mark  = index;
         end
      end
      while (batch.size() < srb_pkg::RESULT_LIMIT && ring_valid[head_slot]) begin
         ring_valid[head_slot] = 1'b0;
         if (held_bytes > 0) held_bytes--;
         item.kind    = srb_pkg::KIND_DATA;
         item.data    = ring_bytes[head_slot];
         item.index   = next_index;
         item.held    = held_bytes[srb_pkg::COUNT_W-1:0];
         item.run_end = 1'b0;
         batch.push_back(item);
         next_index++;
         head_slot = (head_slot + 1) % srb_pkg::WINDOW_BYTES;
      end
      // hold the close back when a full run already went out
      if (batch.size() < srb_pkg::RESULT_LIMIT && end_known && next_index == end_mark) begin
         foreach (ring_valid[i]) ring_valid[i] = 1'b0;
         held_bytes    = 0;
         stream_closed = 1'b1;
         item.kind     = srb_pkg::KIND_CLOSE;
         item.data     = '0;
         item.index    = end_mark;
         item.held     = '0;
         item.run_end  = 1'b0;
         batch.push_back(item);
      end
      if (batch.size() > 0) begin
         item = batch.pop_back();
         item.run_end = 1'b1;
         batch.push_back(item);
      end
      foreach (batch[i]) expected_deliveries.push_back(batch[i]);
   endtask

   task automatic compare_delivery();
      delivery_type seen;
      delivery_type want;
      seen.kind    = rsp_tuser;
      seen.data    = rsp_tdata[0 +: srb_pkg::BYTE_W];
      seen.index   = rsp_tdata[srb_pkg::BYTE_W +: srb_pkg::INDEX_W];
      seen.held    = rsp_tdata[srb_pkg::BYTE_W + srb_pkg::INDEX_W +: srb_pkg::COUNT_W];
      seen.run_end = rsp_tlast;
      if (expected_deliveries.size() == 0) begin
         if (error_total < 10)
            $display("unexpected result: kind %0d byte %02h index %08h pending %0d last %0d",
                     seen.kind, seen.data, seen.index, seen.held, seen.run_end);
         error_total++;
      end else begin
         want = expected_deliveries.pop_front();
         if (seen.kind !== want.kind || seen.data !== want.data || seen.index !== want.index
             || seen.held !== want.held || seen.run_end !== want.run_end) begin
            if (error_total < 10) begin
               $display("result error: expected kind %0d byte %02h index %08h pending %0d last %0d",
                        want.kind, want.data, want.index, want.held, want.run_end);
               $display("              actual   kind %0d byte %02h index %08h pending %0d last %0d",
                        seen.kind, seen.data, seen.index, seen.held, seen.run_end);
            end
            error_total++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (ring_valid[i]) ring_valid[i] = 1'b0;
         next_index    = '0;
         end_mark      = '0;
         end_known     = 1'b0;
         stream_closed = 1'b0;
         held_bytes    = 0;
         head_slot     = 0;
         expected_deliveries.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_delivery();
         if (req_tvalid && req_tready)
            absorb_transfer(req_tdata[0 +: srb_pkg::INDEX_W],
                            req_tdata[srb_pkg::INDEX_W +: srb_pkg::BYTE_W],
                            req_tuser, req_tlast,
                            req_tdata[srb_pkg::INDEX_W + srb_pkg::BYTE_W +: srb_pkg::SPACE_W]);
      end
      mismatch_count      <= error_total;
      outstanding_results <= expected_deliveries.size();
      predicted_next      <= next_index;
   end

endmodule

FILE: test/stream_byte_reassembler_unit_test.sv
// Testbench top for the stream byte reassembler: clock, reset, byte stimulus and verdict.
// Depends on srb_pkg, the block under test and reassembly_checker.
`timescale 1ns / 100ps

module stream_byte_reassembler_unit_test;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 336;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   // stream_index[31:0], byte_value[39:32], available_space[46:40], zero fill
   logic [srb_pkg::REQ_DATA_W-1:0] req_tdata;
   // byte_present
   logic                           req_tuser;
   logic                           req_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // out_byte[7:0], out_index[39:8], pending_count[46:40], zero fill
   logic [srb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   // result_kind
   logic                           rsp_tuser;
   logic                           rsp_tlast;

   int                             mismatch_count;
   int                             outstanding_results;
   logic [srb_pkg::INDEX_W-1:0]    predicted_next;
   int                             cycle_count = 0;
   logic                           quiet;

   stream_byte_reassembler_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   reassembly_checker delivery_check (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .req_tuser           (req_tuser),
      .req_tlast           (req_tlast),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .rsp_tuser           (rsp_tuser),
      .rsp_tlast           (rsp_tlast),
      .mismatch_count      (mismatch_count),
      .outstanding_results (outstanding_results),
      .predicted_next      (predicted_next)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   assign quiet = (cycle_count >= 400 && cycle_count < 1000);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_tready  <= quiet || ($urandom_range(0, 99) >= 20);
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   task automatic send_byte(input logic [31:0] index, input logic [7:0] value,
                            input logic present, input logic final_mark,
                            input logic [6:0] space);
      while (!quiet && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, space, value, index};
      req_tuser  <= present;
      req_tlast  <= final_mark;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      int          sent;
      int          roll;
      int          len;
      int          k;
      int          pos;
      bit          descending;
      logic [31:0] base;
      logic [31:0] start;
      logic [6:0]  space;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_byte(32'd0, 8'h00, 1'b1, 1'b0, 7'd64);
      send_byte(32'd1, 8'hFF, 1'b1, 1'b0, 7'd0);
      // space above the window saturates: offset 64 drops, offset 63 lands in slot 0
      send_byte(32'd65, 8'h5A, 1'b1, 1'b0, 7'd127);
      send_byte(32'd64, 8'hA5, 1'b1, 1'b0, 7'd127);
      send_byte(32'd3, 8'h33, 1'b1, 1'b0, 7'd10);
      send_byte(32'd3, 8'hCC, 1'b1, 1'b0, 7'd10);
      send_byte(32'd2, 8'h22, 1'b1, 1'b0, 7'd2);
      send_byte(32'd0, 8'h11, 1'b0, 1'b0, 7'd64);
      send_byte(32'd1, 8'hFF, 1'b1, 1'b0, 7'd1);
      send_byte(32'd0, 8'h77, 1'b1, 1'b0, 7'd64);
      send_byte(32'hFFFF_FFFF, 8'h88, 1'b1, 1'b0, 7'd64);
      send_byte(32'd200, 8'h99, 1'b1, 1'b1, 7'd64);
      send_byte(32'd300, 8'h00, 1'b0, 1'b1, 7'd127);
      send_byte(32'hFFFF_FFF0, 8'h00, 1'b0, 1'b1, 7'd64);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         base = predicted_next;
         if (roll < 80) begin
            start = base + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40));
            len = $urandom_range(1, 8);
            descending = $urandom_range(0, 1);
            for (k = 0; k < len; k++) begin
               pos = descending ? len - 1 - k : k;
               space = ($urandom_range(0, 9) < 7) ? 7'd64 : 7'($urandom_range(0, 127));
               send_byte(start + pos, 8'($urandom), 1'b1, 1'b0, space);
            end
            sent += len;
         end else if (roll < 90) begin
            send_byte($urandom, 8'($urandom), 1'($urandom), 1'b0,
                      7'($urandom_range(0, 127)));
            sent++;
         end else begin
            // keep end marks far ahead so the stream stays open
            send_byte(base + $urandom_range(200, 32'h3FFF_FFFF), 8'($urandom), 1'($urandom),
                      1'b1, 7'($urandom_range(0, 127)));
            sent++;
         end
      end

      wait_idle();
      base = predicted_next;
      send_byte(base + 32'd5, 8'($urandom), 1'b1, 1'b1, 7'd64);
      send_byte(base + 32'd64, 8'h00, 1'b0, 1'b1, 7'd64);
      for (k = 1; k < srb_pkg::WINDOW_BYTES; k++)
         send_byte(base + k, 8'($urandom), 1'b1, 1'b0, 7'd64);
      // full-window run, then the close on the following transfer
      send_byte(base, 8'($urandom), 1'b1, 1'b0, 7'd64);
      send_byte(32'd0, 8'h00, 1'b0, 1'b0, 7'd0);
      for (k = 0; k < 4; k++)
         send_byte($urandom, 8'($urandom), 1'($urandom), 1'($urandom),
                   7'($urandom_range(0, 127)));
      wait_idle();

      if (mismatch_count == 0 && outstanding_results == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/srb_pkg.sv
hw/rtl/srb_ram.sv
hw/rtl/stream_byte_reassembler_unit.sv
test/reassembly_checker.sv
test/stream_byte_reassembler_unit_test.sv
